FILE: hw/rtl/sult_pkg.sv
// ----------------------------------------------------------------------------
// sult_pkg: shared types and codes for the sorted unique list table
// Command and result layouts plus the opcode and status codes.
// ----------------------------------------------------------------------------
package sult_pkg;

    localparam int OPCODE_W   = 3;
    localparam int KEY_IN_W   = 32;
    localparam int POSITION_W = 4;
    localparam int STATUS_W   = 3;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 5;

    localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_KEY = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_AT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ       = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [KEY_IN_W-1:0]   key;
        logic [POSITION_W-1:0] position;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_out;
        logic                found;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

FILE: hw/rtl/sult_key_ram.sv
// ----------------------------------------------------------------------------
// sult_key_ram: key storage for the sorted list table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sult_key_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sorted_unique_list_table_core.sv
// ----------------------------------------------------------------------------
// sorted_unique_list_table_core: bounded sorted set of unique keys
// Keys sit in ascending order in a single-port-read key RAM; a small sequencer
// scans and shifts entries one per cycle through one shared comparator.
// ----------------------------------------------------------------------------
// Usage: raise start with a command while busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off.
// Clear, unused opcodes, bad indexes and operations on an empty table answer
// straight from idle. Read fetches the key and answers from the fetch state.
// Query, insert and remove by key scan the table one entry per cycle until
// the first key not below the given key or the last entry; insert then
// shifts the upper entries up one per cycle and places the key, or appends it
// when it goes at the end, and both removes shift the upper entries down one
// per cycle unless the last entry goes. The worst case is an insert into a
// table one short of full: the scan and the shift share the single read port
// of the key RAM, so together they read each entry once and the one at the slot twice.
// ----------------------------------------------------------------------------
module sorted_unique_list_table_core #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  sult_pkg::cmd_t command,
    output logic           busy,
    output logic           done,
    output sult_pkg::rsp_t result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > sult_pkg::POSITION_W) ? CW : sult_pkg::POSITION_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [AW-1:0]                   slot_reg, slot_next;
    logic [sult_pkg::OPCODE_W-1:0]   op_reg, op_next;
    logic [KEY_WIDTH-1:0]            key_reg, key_next;
    logic [sult_pkg::DATA_W-1:0]     data_reg, data_next;
    logic                            done_reg, done_next;
    sult_pkg::rsp_t                  rsp_reg, rsp_next;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [KEY_WIDTH-1:0]            ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [KEY_WIDTH-1:0]            rd_key;

    logic                            fin;
    logic [sult_pkg::STATUS_W-1:0]   fin_status;
    logic [sult_pkg::DATA_W-1:0]     fin_data;
    logic                            fin_found;

    logic [KEY_WIDTH-1:0]            key_in;
    logic [PW-1:0]                   pos_x;
    logic                            pos_ok;
    logic                            below;
    logic                            match;
    logic                            scan_more;
    logic [CW-1:0]                   idx_c;
    logic [CW-1:0]                   slot_scan;
    logic                            full;

    sult_key_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_key)
    );

    assign key_in    = KEY_WIDTH'(command.key);
    assign pos_x     = PW'(command.position);
    assign pos_ok    = pos_x < PW'(count_reg);
    assign idx_c     = CW'(idx_reg);
    assign below     = rd_key < key_reg;
    assign match     = !below && (rd_key == key_reg);
    assign scan_more = below && ((idx_c + CW'(1)) < count_reg);
    assign slot_scan = below ? (idx_c + CW'(1)) : idx_c;
    assign full      = count_reg == CW'(CAPACITY);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = rd_key;
        ram_raddr  = idx_reg;

        fin        = 1'b0;
        fin_status = sult_pkg::ST_OK;
        fin_data   = '0;
        fin_found  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = command.opcode;
                    key_next = key_in;
                    priority if (command.opcode == sult_pkg::OP_INSERT ||
                                 command.opcode == sult_pkg::OP_REMOVE_KEY ||
                                 command.opcode == sult_pkg::OP_QUERY)
                    begin
                        if (count_reg == '0)
                        begin
                            // empty table: answer at once
                            fin = 1'b1;
                            if (command.opcode == sult_pkg::OP_INSERT)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = key_in;
                                count_next = CW'(1);
                            end
                            else if (command.opcode == sult_pkg::OP_REMOVE_KEY)
                            begin
                                fin_status = sult_pkg::ST_NOT_FOUND;
                            end
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (command.opcode == sult_pkg::OP_REMOVE_AT ||
                             command.opcode == sult_pkg::OP_READ)
                    begin
                        if (!pos_ok)
                        begin
                            fin        = 1'b1;
                            fin_status = sult_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            ram_raddr  = AW'(pos_x);
                            idx_next   = AW'(pos_x);
                            state_next = S_FETCH;
                        end
                    end
                    else if (command.opcode == sult_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                        fin        = 1'b1;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_more)
                begin
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = idx_reg + AW'(1);
                end
                else
                begin
                    unique case (op_reg)
                        sult_pkg::OP_QUERY:
                        begin
                            fin       = 1'b1;
                            fin_found = match;
                        end
                        sult_pkg::OP_REMOVE_KEY:
                        begin
                            if (!match)
                            begin
                                fin        = 1'b1;
                                fin_status = sult_pkg::ST_NOT_FOUND;
                            end
                            else if (slot_scan == count_reg - CW'(1))
                            begin
                                count_next = count_reg - CW'(1);
                                fin        = 1'b1;
                            end
                            else
                            begin
                                // close the gap from the matched slot upward
                                idx_next   = AW'(slot_scan);
                                ram_raddr  = AW'(slot_scan) + AW'(1);
                                data_next  = '0;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        default:
                        begin
                            if (match)
                            begin
                                fin        = 1'b1;
                                fin_status = sult_pkg::ST_DUPLICATE;
                            end
                            else if (full)
                            begin
                                fin        = 1'b1;
                                fin_status = sult_pkg::ST_FULL;
                            end
                            else if (slot_scan == count_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(slot_scan);
                                ram_wdata  = key_reg;
                                count_next = count_reg + CW'(1);
                                fin        = 1'b1;
                            end
                            else
                            begin
                                // open a hole at the slot, top entry first
                                slot_next  = AW'(slot_scan);
                                idx_next   = AW'(count_reg);
                                ram_raddr  = AW'(count_reg) - AW'(1);
                                state_next = S_SHIFT_UP;
                            end
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = rd_key;
                if (idx_reg - AW'(1) == slot_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next  = idx_reg - AW'(1);
                    ram_raddr = idx_reg - AW'(2);
                end
            end

            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = key_reg;
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
            end

            S_SHIFT_DN:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = rd_key;
                if (idx_c + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    fin        = 1'b1;
                    fin_data   = data_reg;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = idx_reg + AW'(2);
                end
            end

            S_FETCH:
            begin
                if (op_reg == sult_pkg::OP_READ)
                begin
                    fin      = 1'b1;
                    fin_data = sult_pkg::DATA_W'(rd_key);
                end
                else if (idx_c + CW'(1) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    fin        = 1'b1;
                    fin_data   = sult_pkg::DATA_W'(rd_key);
                end
                else
                begin
                    // hold the removed key while the upper entries move down
                    data_next  = sult_pkg::DATA_W'(rd_key);
                    ram_raddr  = idx_reg + AW'(1);
                    state_next = S_SHIFT_DN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next           = S_IDLE;
            done_next            = 1'b1;
            rsp_next.status      = fin_status;
            rsp_next.data_out    = fin_data;
            rsp_next.found       = fin_found;
            rsp_next.entry_count = sult_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            slot_reg  <= '0;
            op_reg    <= '0;
            key_reg   <= '0;
            data_reg  <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
            op_reg    <= op_next;
            key_reg   <= key_next;
            data_reg  <= data_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
